// ===== rtl/stok_pkg.sv =====
package stok_pkg;

   // Counter widths for byte offsets and line numbers.
   localparam int OFFSET_WIDTH = 24;
   localparam int LINE_WIDTH   = 20;

   typedef logic [OFFSET_WIDTH-1:0] offset_type;
   typedef logic [LINE_WIDTH-1:0]   line_type;

   localparam offset_type POS_MAX  = {OFFSET_WIDTH{1'b1}};
   localparam line_type   LINE_MAX = {LINE_WIDTH{1'b1}};

   // Scanner states.
   typedef enum logic [3:0] {
      ST_IDLE       = 4'd0,
      ST_IDENT      = 4'd1,
      ST_NUMBER     = 4'd2,
      ST_STRING     = 4'd3,
      ST_CHAR_OPEN  = 4'd4,
      ST_CHAR_CLOSE = 4'd5,
      ST_OP         = 4'd6,
      ST_LINE_CMT   = 4'd7,
      ST_BLOCK_CMT  = 4'd8
   } scan_state_type;

   // Dense token kind codes.
   typedef enum logic [5:0] {
      KIND_EOF        = 6'd0,
      KIND_IDENT      = 6'd1,
      KIND_NUMBER     = 6'd2,
      KIND_STRING     = 6'd3,
      KIND_CHAR       = 6'd4,
      KIND_MUL        = 6'd5,
      KIND_MUL_ASSIGN = 6'd6,
      KIND_DIV        = 6'd7,
      KIND_DIV_ASSIGN = 6'd8,
      KIND_ADD        = 6'd9,
      KIND_ADD_ASSIGN = 6'd10,
      KIND_SUB        = 6'd11,
      KIND_SUB_ASSIGN = 6'd12,
      KIND_ARROW      = 6'd13,
      KIND_MOD        = 6'd14,
      KIND_MOD_ASSIGN = 6'd15,
      KIND_ASSIGN     = 6'd16,
      KIND_EQ         = 6'd17,
      KIND_GT         = 6'd18,
      KIND_GE         = 6'd19,
      KIND_LT         = 6'd20,
      KIND_LE         = 6'd21,
      KIND_BIT_AND    = 6'd22,
      KIND_LOG_AND    = 6'd23,
      KIND_BIT_OR     = 6'd24,
      KIND_LOG_OR     = 6'd25,
      KIND_NOT        = 6'd26,
      KIND_NE         = 6'd27,
      KIND_XOR        = 6'd28,
      KIND_SEMI       = 6'd29,
      KIND_COLON      = 6'd30,
      KIND_DOT        = 6'd31,
      KIND_COMMA      = 6'd32,
      KIND_LPAREN     = 6'd33,
      KIND_RPAREN     = 6'd34,
      KIND_LBRACE     = 6'd35,
      KIND_RBRACE     = 6'd36,
      KIND_LBRACK     = 6'd37,
      KIND_RBRACK     = 6'd38,
      KIND_ILLEGAL    = 6'd39
   } token_kind_type;

   // Character codes.
   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_BANG       = 8'h21;
   localparam logic [7:0] CH_DQUOTE     = 8'h22;
   localparam logic [7:0] CH_PERCENT    = 8'h25;
   localparam logic [7:0] CH_AMP        = 8'h26;
   localparam logic [7:0] CH_SQUOTE     = 8'h27;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_COMMA      = 8'h2C;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_POINT      = 8'h2E;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_DIGIT_0    = 8'h30;
   localparam logic [7:0] CH_DIGIT_9    = 8'h39;
   localparam logic [7:0] CH_COLON      = 8'h3A;
   localparam logic [7:0] CH_SEMI       = 8'h3B;
   localparam logic [7:0] CH_LT         = 8'h3C;
   localparam logic [7:0] CH_EQUAL      = 8'h3D;
   localparam logic [7:0] CH_GT         = 8'h3E;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CH_LBRACK     = 8'h5B;
   localparam logic [7:0] CH_RBRACK     = 8'h5D;
   localparam logic [7:0] CH_CARET      = 8'h5E;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CH_LBRACE     = 8'h7B;
   localparam logic [7:0] CH_BAR        = 8'h7C;
   localparam logic [7:0] CH_RBRACE     = 8'h7D;

   // One result token without its run marker.
   typedef struct packed {
      token_kind_type kind;
      offset_type     start;
      offset_type     length;
      line_type       line;
      logic [7:0]     byte_value;
      logic           unterminated;
   } token_type;

   // Up to two tokens produced by one request.
   typedef struct packed {
      logic      push;
      logic      two;
      token_type first;
      token_type second;
   } bundle_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
             (c == CH_UNDERSCORE);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
   endfunction

   // Kind of a lone operator or punctuation byte.
   function automatic token_kind_type single_kind(input logic [7:0] c);
      token_kind_type k;
      unique case (c)
         CH_STAR:    k = KIND_MUL;
         CH_SLASH:   k = KIND_DIV;
         CH_PLUS:    k = KIND_ADD;
         CH_MINUS:   k = KIND_SUB;
         CH_PERCENT: k = KIND_MOD;
         CH_EQUAL:   k = KIND_ASSIGN;
         CH_GT:      k = KIND_GT;
         CH_LT:      k = KIND_LT;
         CH_AMP:     k = KIND_BIT_AND;
         CH_BAR:     k = KIND_BIT_OR;
         CH_BANG:    k = KIND_NOT;
         CH_CARET:   k = KIND_XOR;
         CH_SEMI:    k = KIND_SEMI;
         CH_COLON:   k = KIND_COLON;
         CH_POINT:   k = KIND_DOT;
         CH_COMMA:   k = KIND_COMMA;
         CH_LPAREN:  k = KIND_LPAREN;
         CH_RPAREN:  k = KIND_RPAREN;
         CH_LBRACE:  k = KIND_LBRACE;
         CH_RBRACE:  k = KIND_RBRACE;
         CH_LBRACK:  k = KIND_LBRACK;
         CH_RBRACK:  k = KIND_RBRACK;
         default:    k = KIND_ILLEGAL;
      endcase
      return k;
   endfunction

   // Operators that may combine with the following byte.
   function automatic logic may_pair(input logic [7:0] c);
      return (c == CH_STAR) || (c == CH_SLASH) || (c == CH_PLUS) || (c == CH_MINUS) ||
             (c == CH_PERCENT) || (c == CH_EQUAL) || (c == CH_GT) || (c == CH_LT) ||
             (c == CH_AMP) || (c == CH_BAR) || (c == CH_BANG);
   endfunction

   // Two-byte operator kind, KIND_EOF when the bytes do not combine.
   function automatic token_kind_type pair_kind(input logic [7:0] a, input logic [7:0] c);
      token_kind_type k;
      k = KIND_EOF;
      if (a == CH_MINUS && c == CH_GT) begin
         k = KIND_ARROW;
      end else if (a == CH_AMP && c == CH_AMP) begin
         k = KIND_LOG_AND;
      end else if (a == CH_BAR && c == CH_BAR) begin
         k = KIND_LOG_OR;
      end else if (c == CH_EQUAL && a != CH_AMP && a != CH_BAR) begin
         k = token_kind_type'(6'(single_kind(a)) + 6'd1);
      end
      return k;
   endfunction

   function automatic token_type make_token(input token_kind_type kind,
                                            input offset_type start,
                                            input offset_type length,
                                            input line_type line,
                                            input logic [7:0] byte_value,
                                            input logic unterminated);
      token_type t;
      t.kind         = kind;
      t.start        = start;
      t.length       = length;
      t.line         = line;
      t.byte_value   = byte_value;
      t.unterminated = unterminated;
      return t;
   endfunction

endpackage

// ===== rtl/stok_lexer.sv =====
module stok_lexer import stok_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [7:0] req_char_byte,
   input  logic       queue_ready,
   output bundle_type push_bundle
);

   localparam offset_type LEN_ONE = offset_type'(1);
   localparam offset_type LEN_TWO = offset_type'(2);

   logic           in_valid_ff, in_valid_in;
   logic           in_mode_ff;
   logic [7:0]     in_char_ff;

   scan_state_type state_ff, state_in;
   logic [7:0]     pending_ff, pending_in;
   offset_type     position_ff, position_in;
   offset_type     token_start_ff, token_start_in;
   line_type       line_ff, line_in;
   logic           seen_point_ff, seen_point_in;
   logic           seen_star_ff, seen_star_in;
   logic [7:0]     char_value_ff, char_value_in;

   logic           accept;
   logic           fire;
   logic           at_end;
   logic [7:0]     cur_byte;
   offset_type     len;
   offset_type     pos_inc;
   line_type       line_inc;
   token_kind_type op_kind;
   token_kind_type lone_kind;
   logic           do_begin;
   logic           begin_emits;
   logic           is_space;
   logic           bump;
   logic           cand_a_valid, cand_b_valid;
   token_type      cand_a, cand_b;

   // Handshake: the input register is emptied whenever the result queue has room.
   assign fire      = in_valid_ff & queue_ready;
   assign req_stall = in_valid_ff & ~queue_ready;
   assign accept    = req_valid & ~req_stall;
   assign in_valid_in = accept | (in_valid_ff & ~fire);

   // Shared decode of the registered byte.
   assign cur_byte  = in_char_ff;
   assign at_end    = in_mode_ff | (cur_byte == CH_NUL);
   assign len       = position_ff - token_start_ff;
   assign pos_inc   = (position_ff == POS_MAX) ? position_ff : position_ff + LEN_ONE;
   assign line_inc  = (line_ff == LINE_MAX) ? line_ff : line_ff + line_type'(1);
   assign op_kind   = pair_kind(pending_ff, cur_byte);
   assign lone_kind = single_kind(cur_byte);
   assign is_space  = (cur_byte == CH_SPACE) || (cur_byte == CH_TAB) || (cur_byte == CH_CR);
   assign begin_emits = !is_alpha(cur_byte) && !is_digit(cur_byte) && !is_space &&
                        (cur_byte != CH_NEWLINE) && !may_pair(cur_byte) &&
                        (cur_byte != CH_SQUOTE) && (cur_byte != CH_DQUOTE);

   // Decide whether this byte starts a fresh lexeme after closing the open one.
   always_comb begin
      do_begin = 1'b0;
      if (!at_end) begin
         unique case (state_ff)
            ST_IDENT:      do_begin = !(is_alpha(cur_byte) || is_digit(cur_byte));
            ST_NUMBER:     do_begin = !is_digit(cur_byte) &&
                                      !(cur_byte == CH_POINT && !seen_point_ff);
            ST_OP:         do_begin = (op_kind == KIND_EOF) &&
                                      !(pending_ff == CH_SLASH &&
                                        (cur_byte == CH_SLASH || cur_byte == CH_STAR));
            ST_STRING, ST_CHAR_OPEN, ST_CHAR_CLOSE,
            ST_LINE_CMT, ST_BLOCK_CMT: do_begin = 1'b0;
            default:       do_begin = 1'b1;
         endcase
      end
   end

   // Next scanner state.
   always_comb begin
      state_in       = state_ff;
      pending_in     = pending_ff;
      position_in    = position_ff;
      token_start_in = token_start_ff;
      line_in        = line_ff;
      seen_point_in  = seen_point_ff;
      seen_star_in   = seen_star_ff;
      char_value_in  = char_value_ff;
      bump           = 1'b0;
      if (fire) begin
         if (at_end) begin
            state_in       = ST_IDLE;
            pending_in     = CH_NUL;
            position_in    = '0;
            token_start_in = '0;
            line_in        = line_type'(1);
            seen_point_in  = 1'b0;
            seen_star_in   = 1'b0;
            char_value_in  = CH_NUL;
         end else begin
            position_in = pos_inc;
            unique case (state_ff)
               ST_NUMBER: begin
                  if (!do_begin && cur_byte == CH_POINT) seen_point_in = 1'b1;
               end
               ST_STRING: begin
                  if (cur_byte == CH_DQUOTE) state_in = ST_IDLE;
                  else if (cur_byte == CH_NEWLINE) bump = 1'b1;
               end
               ST_CHAR_OPEN: begin
                  char_value_in = cur_byte;
                  state_in      = ST_CHAR_CLOSE;
               end
               ST_CHAR_CLOSE: begin
                  state_in = ST_IDLE;
               end
               ST_OP: begin
                  if (op_kind != KIND_EOF) begin
                     state_in = ST_IDLE;
                  end else if (pending_ff == CH_SLASH && cur_byte == CH_SLASH) begin
                     state_in = ST_LINE_CMT;
                  end else if (pending_ff == CH_SLASH && cur_byte == CH_STAR) begin
                     seen_star_in = 1'b0;
                     state_in     = ST_BLOCK_CMT;
                  end
               end
               ST_LINE_CMT: begin
                  if (cur_byte == CH_NEWLINE) begin
                     bump     = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               ST_BLOCK_CMT: begin
                  if (seen_star_ff && cur_byte == CH_SLASH) begin
                     seen_star_in = 1'b0;
                     state_in     = ST_IDLE;
                  end else begin
                     seen_star_in = (cur_byte == CH_STAR);
                     if (cur_byte == CH_NEWLINE) bump = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            // Start of a new lexeme.
            if (do_begin) begin
               state_in       = ST_IDLE;
               token_start_in = position_ff;
               if (is_alpha(cur_byte)) begin
                  state_in = ST_IDENT;
               end else if (is_digit(cur_byte)) begin
                  state_in      = ST_NUMBER;
                  seen_point_in = 1'b0;
               end else if (cur_byte == CH_NEWLINE) begin
                  bump = 1'b1;
               end else if (may_pair(cur_byte)) begin
                  pending_in = cur_byte;
                  state_in   = ST_OP;
               end else if (cur_byte == CH_SQUOTE) begin
                  char_value_in = CH_NUL;
                  state_in      = ST_CHAR_OPEN;
               end else if (cur_byte == CH_DQUOTE) begin
                  token_start_in = pos_inc;
                  state_in       = ST_STRING;
               end
            end
            if (bump) line_in = line_inc;
         end
      end
   end

   // Tokens: one from closing the open lexeme, one from the new byte or the end marker.
   always_comb begin
      cand_a_valid = 1'b0;
      cand_b_valid = 1'b0;
      cand_a       = '0;
      cand_b       = '0;
      if (at_end) begin
         unique case (state_ff)
            ST_IDENT: begin
               cand_a_valid = 1'b1;
               cand_a = make_token(KIND_IDENT, token_start_ff, len, line_ff, CH_NUL, 1'b0);
            end
            ST_NUMBER: begin
               cand_a_valid = 1'b1;
               cand_a = make_token(KIND_NUMBER, token_start_ff, len, line_ff, CH_NUL, 1'b0);
            end
            ST_STRING: begin
               cand_a_valid = 1'b1;
               cand_a = make_token(KIND_ILLEGAL, token_start_ff, len, line_ff, CH_NUL, 1'b1);
            end
            ST_CHAR_OPEN, ST_CHAR_CLOSE: begin
               cand_a_valid = 1'b1;
               cand_a = make_token(KIND_CHAR, token_start_ff, len, line_ff, char_value_ff,
                                   1'b0);
            end
            ST_OP: begin
               cand_a_valid = 1'b1;
               cand_a = make_token(single_kind(pending_ff), token_start_ff, LEN_ONE, line_ff,
                                   CH_NUL, 1'b0);
            end
            default: begin
            end
         endcase
         cand_b_valid = 1'b1;
         cand_b = make_token(KIND_EOF, position_ff, '0, line_ff, CH_NUL, 1'b0);
      end else begin
         unique case (state_ff)
            ST_IDENT: begin
               cand_a_valid = do_begin;
               cand_a = make_token(KIND_IDENT, token_start_ff, len, line_ff, CH_NUL, 1'b0);
            end
            ST_NUMBER: begin
               cand_a_valid = do_begin;
               cand_a = make_token(KIND_NUMBER, token_start_ff, len, line_ff, CH_NUL, 1'b0);
            end
            ST_STRING: begin
               cand_a_valid = (cur_byte == CH_DQUOTE);
               cand_a = make_token(KIND_STRING, token_start_ff, len, line_ff, CH_NUL, 1'b0);
            end
            ST_CHAR_CLOSE: begin
               cand_a_valid = 1'b1;
               cand_a = make_token(KIND_CHAR, token_start_ff, len + LEN_ONE, line_ff,
                                   char_value_ff, 1'b0);
            end
            ST_OP: begin
               if (op_kind != KIND_EOF) begin
                  cand_a_valid = 1'b1;
                  cand_a = make_token(op_kind, token_start_ff, LEN_TWO, line_ff, CH_NUL, 1'b0);
               end else begin
                  cand_a_valid = do_begin;
                  cand_a = make_token(single_kind(pending_ff), token_start_ff, LEN_ONE, line_ff,
                                      CH_NUL, 1'b0);
               end
            end
            default: begin
            end
         endcase
         if (do_begin && begin_emits) begin
            cand_b_valid = 1'b1;
            cand_b = make_token(lone_kind, position_ff, LEN_ONE, line_ff,
                                (lone_kind == KIND_ILLEGAL) ? cur_byte : CH_NUL, 1'b0);
         end
      end
   end

   // Packed tokens toward the result queue, first slot filled first.
   always_comb begin
      push_bundle.push   = fire & (cand_a_valid | cand_b_valid);
      push_bundle.two    = cand_a_valid & cand_b_valid;
      push_bundle.first  = cand_a_valid ? cand_a : cand_b;
      push_bundle.second = cand_b;
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_mode_ff <= req_mode;
         in_char_ff <= req_char_byte;
      end
   end

   // Control and scanner state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         state_ff       <= ST_IDLE;
         pending_ff     <= CH_NUL;
         position_ff    <= '0;
         token_start_ff <= '0;
         line_ff        <= line_type'(1);
         seen_point_ff  <= 1'b0;
         seen_star_ff   <= 1'b0;
         char_value_ff  <= CH_NUL;
      end else begin
         in_valid_ff    <= in_valid_in;
         state_ff       <= state_in;
         pending_ff     <= pending_in;
         position_ff    <= position_in;
         token_start_ff <= token_start_in;
         line_ff        <= line_in;
         seen_point_ff  <= seen_point_in;
         seen_star_ff   <= seen_star_in;
         char_value_ff  <= char_value_in;
      end
   end

   // An end marker always returns the scanner to its initial state.
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      fire && at_end |=> state_ff == ST_IDLE && position_ff == '0 &&
                         line_ff == line_type'(1))
      else $error("scanner did not restart after end of input");

   // Every consumed source byte advances the offset until it saturates.
   a_position_steps: assert property (@(posedge clock) disable iff (reset)
      fire && !at_end && position_ff != POS_MAX |=> position_ff == $past(position_ff) + LEN_ONE)
      else $error("byte offset did not advance");

   // A lexeme never starts beyond the next byte offset.
   a_start_order: assert property (@(posedge clock) disable iff (reset)
      position_ff >= token_start_ff)
      else $error("lexeme start lies beyond the current offset");

   // The line counter never wraps to zero.
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line counter reached zero");

endmodule

// ===== rtl/stok_out_queue.sv =====
module stok_out_queue import stok_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  bundle_type push_bundle,
   output logic       queue_ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [5:0] rsp_token_kind,
   output logic [23:0] rsp_start_offset,
   output logic [23:0] rsp_lexeme_length,
   output logic [19:0] rsp_line_number,
   output logic [7:0] rsp_byte_value,
   output logic       rsp_unterminated,
   output logic       rsp_last_in_run
);

   localparam logic [1:0] QUEUE_FULL = 2'd2;

   logic       two_ff    [2];
   token_type  first_ff  [2];
   token_type  second_ff [2];

   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       sub_ff, sub_in;

   logic       take;
   logic       last;
   logic       pop;
   token_type  cur_token;

   // Output side walks the tokens of the head bundle one token at a time.
   assign rsp_valid   = (count_ff != 2'd0);
   assign queue_ready = (count_ff != QUEUE_FULL);
   assign cur_token   = sub_ff ? second_ff[rd_ptr_ff] : first_ff[rd_ptr_ff];
   assign last        = sub_ff | ~two_ff[rd_ptr_ff];
   assign take        = rsp_valid & ~rsp_stall;
   assign pop         = take & last;

   assign rsp_token_kind    = cur_token.kind;
   assign rsp_start_offset  = cur_token.start;
   assign rsp_lexeme_length = cur_token.length;
   assign rsp_line_number   = cur_token.line;
   assign rsp_byte_value    = cur_token.byte_value;
   assign rsp_unterminated  = cur_token.unterminated;
   assign rsp_last_in_run   = last;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push_bundle.push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      sub_in    = take ? ~last : sub_ff;
      count_in  = count_ff + {1'b0, push_bundle.push} - {1'b0, pop};
   end

   // Bundle storage.
   always_ff @(posedge clock) begin
      if (push_bundle.push) begin
         two_ff[wr_ptr_ff]    <= push_bundle.two;
         first_ff[wr_ptr_ff]  <= push_bundle.first;
         second_ff[wr_ptr_ff] <= push_bundle.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         sub_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
      end
   end

   // The scanner only pushes when a slot is free.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_bundle.push |-> count_ff != QUEUE_FULL)
      else $error("result queue overflow");

   // Taking the first of two tokens leaves the second one on offer.
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      take && !last |=> rsp_valid && sub_ff && $stable(rd_ptr_ff))
      else $error("second token of a pair was lost");

   // A finished bundle with no refill lowers the occupancy by one.
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      pop && !push_bundle.push |=> count_ff == $past(count_ff) - 2'd1)
      else $error("queue occupancy wrong after pop");

endmodule

// ===== rtl/source_tokenizer.sv =====
// Path: a taken request is held in the scanner's input register; its tokens are written
// into the result queue once it has room, and the queue offers them on the token port.
// Throughput: one request per cycle while the result queue has room; the tokens of a
// request are offered one at a time, so the token port (one per cycle) sets the sustained rate.
// Reset: synchronous, active high; clears the scanner to line 1, offset 0, and empties
// the two-entry result queue.
module source_tokenizer import stok_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_char_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_token_kind,
   output logic [23:0] rsp_start_offset,
   output logic [23:0] rsp_lexeme_length,
   output logic [19:0] rsp_line_number,
   output logic [7:0]  rsp_byte_value,
   output logic        rsp_unterminated,
   output logic        rsp_last_in_run
);

   logic       queue_ready;
   bundle_type push_bundle;

   // Scanner: input register, lexeme state and token generation.
   stok_lexer u_lexer (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_char_byte (req_char_byte),
      .queue_ready   (queue_ready),
      .push_bundle   (push_bundle)
   );

   // Result queue that serializes token pairs.
   stok_out_queue u_out_queue (
      .clock             (clock),
      .reset             (reset),
      .push_bundle       (push_bundle),
      .queue_ready       (queue_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_start_offset  (rsp_start_offset),
      .rsp_lexeme_length (rsp_lexeme_length),
      .rsp_line_number   (rsp_line_number),
      .rsp_byte_value    (rsp_byte_value),
      .rsp_unterminated  (rsp_unterminated),
      .rsp_last_in_run   (rsp_last_in_run)
   );

endmodule
